@@ rtl/csdg_pkg.sv @@
// shared types, widths and register codes of the circle signed distance grid unit
// no dependencies
`timescale 1ns / 1ps

package csdg_pkg;

  localparam int IDX_W   = 10;   // column / row index
  localparam int STEP_W  = 16;   // grid step, unsigned q4.12
  localparam int COORD_W = 24;   // origin and center, signed q12.12
  localparam int RAD_CFG_W = 23; // radius, unsigned q11.12
  localparam int PROD_W  = IDX_W + STEP_W;  // index times step
  localparam int POS_W   = 28;   // full width point coordinate and delta
  localparam int ABS_W   = POS_W - 1;     // magnitude of a delta
  localparam int SUM_W   = 54;   // sum of squares, q24
  localparam int ROOT_W  = SUM_W / 2;     // integer root, q12
  localparam int REM_W   = ROOT_W + 2;    // partial remainder
  localparam int SD_W    = 28;   // signed distance
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_CELLS  = ROOT_W;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INSIDE_POSITIVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_X_ORIGIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y_ORIGIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X          = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y          = 3'd7;

  localparam logic [RAD_CFG_W-1:0] RADIUS_RST = 23'd4096;
  localparam logic [STEP_W-1:0]    STEP_RST   = 16'd4096;

  typedef struct packed {
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;
  } in_req_t;

  typedef struct packed {
    logic signed [SD_W-1:0] signed_distance;
    logic [IDX_W-1:0]       column_out;
    logic [IDX_W-1:0]       row_out;
  } out_req_t;

  typedef struct packed {
    logic [COORD_W-1:0]   center_x;
    logic [COORD_W-1:0]   center_y;
    logic [RAD_CFG_W-1:0] radius;
    logic                 inside_positive;
    logic [COORD_W-1:0]   grid_x_origin;
    logic [COORD_W-1:0]   grid_y_origin;
    logic [STEP_W-1:0]    step_x;
    logic [STEP_W-1:0]    step_y;
  } cfg_t;

  // what one square root cell hands to the next
  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  rad;
    logic [IDX_W-1:0]  column;
    logic [IDX_W-1:0]  row;
  } cell_t;

endpackage

@@ rtl/circle_signed_distance_grid_unit.sv @@
// top level of the circle signed distance grid unit: registers, input skid, chain, output
// depends on csdg_pkg, csdg_front and csdg_sqrt_cell
`timescale 1ns / 1ps

//  channel   ports                              payload
//  input     in_valid, in_stall, in_data        column, row
//  output    out_valid, out_stall, out_data     signed_distance, column_out, row_out
//  config    cfg_we, cfg_index, cfg_wdata       eight registers, write only
//
//  one request per cycle sustained while no result is held under out_stall; 33 register
//  stages: 5 front stages, one cell per root bit (27), one output stage
//  the whole pipe moves together and halts while a result waits under out_stall;
//  a one-entry skid register still takes a request then, and in_stall is its full flag
//  reset is synchronous, active low; it empties the pipe and loads register defaults

module circle_signed_distance_grid_unit import csdg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_req_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg_r;
  logic     skid_valid_r, skid_valid_nxt;
  in_req_t  skid_req_r;
  logic     out_valid_r;
  out_req_t out_data_r;

  logic     en;        // pipe advance
  logic     in_fire;
  logic     fe_valid;
  in_req_t  fe_req;
  cell_t    chain [NUM_CELLS+1];

  logic [SD_W-1:0] diff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x        <= '0;
      cfg_r.center_y        <= '0;
      cfg_r.radius          <= RADIUS_RST;
      cfg_r.inside_positive <= 1'b0;
      cfg_r.grid_x_origin   <= '0;
      cfg_r.grid_y_origin   <= '0;
      cfg_r.step_x          <= STEP_RST;
      cfg_r.step_y          <= STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:        cfg_r.center_x        <= cfg_wdata;
        REG_CENTER_Y:        cfg_r.center_y        <= cfg_wdata;
        REG_RADIUS:          cfg_r.radius          <= cfg_wdata[RAD_CFG_W-1:0];
        REG_INSIDE_POSITIVE: cfg_r.inside_positive <= cfg_wdata[0];
        REG_GRID_X_ORIGIN:   cfg_r.grid_x_origin   <= cfg_wdata;
        REG_GRID_Y_ORIGIN:   cfg_r.grid_y_origin   <= cfg_wdata;
        REG_STEP_X:          cfg_r.step_x          <= cfg_wdata[STEP_W-1:0];
        REG_STEP_Y:          cfg_r.step_y          <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe halts only when a finished result is held back
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;

  // skid entry goes first, else a fresh request enters directly
  assign fe_valid = skid_valid_r || in_fire;
  assign fe_req   = skid_valid_r ? skid_req_r : in_data;

  always_comb begin
    skid_valid_nxt = skid_valid_r;
    if (en) begin
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else begin
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_fire) begin
      skid_req_r <= in_data;
    end
  end

  // coordinate, deltas and sum of squares
  csdg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .req_valid (fe_valid),
    .req       (fe_req),
    .cfg       (cfg_r),
    .cell_o    (chain[0])
  );

  // square root chain, most significant root bit first
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    csdg_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // distance minus radius, negated in inside-positive mode
  always_comb begin
    diff = {1'b0, chain[NUM_CELLS].root}
           - {{(SD_W-RAD_CFG_W){1'b0}}, cfg_r.radius};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[NUM_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.signed_distance <= cfg_r.inside_positive ? SD_W'(-diff) : diff;
      out_data_r.column_out      <= chain[NUM_CELLS].column;
      out_data_r.row_out         <= chain[NUM_CELLS].row;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/csdg_front.sv @@
// front stages: grid coordinate, delta to center, magnitudes, squares and their sum
// depends on csdg_pkg
`timescale 1ns / 1ps

module csdg_front import csdg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    req_valid,
  input  in_req_t req,
  input  cfg_t    cfg,
  output cell_t   cell_o
);

  // stage 1: index times step
  logic              s1_valid_r;
  logic [PROD_W-1:0] s1_mx_r, s1_my_r;
  in_req_t           s1_req_r;
  // stage 2: point coordinate
  logic              s2_valid_r;
  logic [POS_W-1:0]  s2_x_r, s2_y_r;
  in_req_t           s2_req_r;
  // stage 3: delta magnitudes
  logic              s3_valid_r;
  logic [ABS_W-1:0]  s3_ax_r, s3_ay_r;
  in_req_t           s3_req_r;
  // stage 4: squares
  logic              s4_valid_r;
  logic [SUM_W-1:0]  s4_sqx_r, s4_sqy_r;
  in_req_t           s4_req_r;
  // stage 5: sum, start of the root chain
  cell_t             s5_r;

  logic [POS_W-1:0] x_nxt, y_nxt, dx, dy;
  logic [ABS_W-1:0] ax_nxt, ay_nxt;

  always_comb begin
    x_nxt = {{(POS_W-COORD_W){cfg.grid_x_origin[COORD_W-1]}}, cfg.grid_x_origin}
            + {{(POS_W-PROD_W){1'b0}}, s1_mx_r};
    y_nxt = {{(POS_W-COORD_W){cfg.grid_y_origin[COORD_W-1]}}, cfg.grid_y_origin}
            + {{(POS_W-PROD_W){1'b0}}, s1_my_r};
    dx = {{(POS_W-COORD_W){cfg.center_x[COORD_W-1]}}, cfg.center_x} - s2_x_r;
    dy = {{(POS_W-COORD_W){cfg.center_y[COORD_W-1]}}, cfg.center_y} - s2_y_r;
    ax_nxt = dx[POS_W-1] ? ABS_W'(-dx) : dx[ABS_W-1:0];
    ay_nxt = dy[POS_W-1] ? ABS_W'(-dy) : dy[ABS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_r.valid <= 1'b0;
    end else if (en) begin
      s1_valid_r <= req_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_r.valid <= s4_valid_r;
    end
    if (en) begin
      s1_req_r <= req;
      s1_mx_r  <= PROD_W'(req.column) * PROD_W'(cfg.step_x);
      s1_my_r  <= PROD_W'(req.row) * PROD_W'(cfg.step_y);
      s2_req_r <= s1_req_r;
      s2_x_r   <= x_nxt;
      s2_y_r   <= y_nxt;
      s3_req_r <= s2_req_r;
      s3_ax_r  <= ax_nxt;
      s3_ay_r  <= ay_nxt;
      s4_req_r <= s3_req_r;
      s4_sqx_r <= SUM_W'(s3_ax_r) * SUM_W'(s3_ax_r);
      s4_sqy_r <= SUM_W'(s3_ay_r) * SUM_W'(s3_ay_r);
      s5_r.rem    <= '0;
      s5_r.root   <= '0;
      s5_r.rad    <= s4_sqx_r + s4_sqy_r;
      s5_r.column <= s4_req_r.column;
      s5_r.row    <= s4_req_r.row;
    end
  end

  assign cell_o = s5_r;

endmodule

@@ rtl/csdg_sqrt_cell.sv @@
// one cell of the square root chain: one root bit from two radicand bits
// depends on csdg_pkg
`timescale 1ns / 1ps

module csdg_sqrt_cell import csdg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t            cell_r;
  logic [REM_W-1:0] rem_sh, trial;
  logic             ge;

  always_comb begin
    rem_sh = {cell_i.rem[REM_W-3:0], cell_i.rad[SUM_W-1:SUM_W-2]};
    trial  = {cell_i.root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_i.valid;
    end
    if (en) begin
      cell_r.rem    <= ge ? rem_sh - trial : rem_sh;
      cell_r.root   <= {cell_i.root[ROOT_W-2:0], ge};
      cell_r.rad    <= {cell_i.rad[SUM_W-3:0], 2'b00};
      cell_r.column <= cell_i.column;
      cell_r.row    <= cell_i.row;
    end
  end

  assign cell_o = cell_r;

endmodule
